[design/sha1_pkg.sv]
// sha1_pkg: shared types and constants for the sha1_hash block
// item structs for both channels, initial hash words and round constants
// no dependencies
package sha1_pkg;

    typedef logic [31:0] word_t;

    // one input transfer: a message byte or the end-of-message mark
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    // one output transfer: a digest word and its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int DIGEST_WORDS = 5;
    localparam int WINDOW_WORDS = 16;
    localparam int ROUNDS       = 80;
    localparam int TOTAL_W      = 61;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hefcdab89;
    localparam word_t H2 = 32'h98badcfe;
    localparam word_t H3 = 32'h10325476;
    localparam word_t H4 = 32'hc3d2e1f0;

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    // initial chaining word by position
    function automatic word_t init_word(input logic [2:0] idx);
        word_t w;
        case (idx)
            3'd0:    w = H0;
            3'd1:    w = H1;
            3'd2:    w = H2;
            3'd3:    w = H3;
            default: w = H4;
        endcase
        return w;
    endfunction

endpackage

[design/sha1_hash.sv]
// sha1_hash: streaming SHA-1 digest engine, one round per cycle
// depends on sha1_pkg for item types and constants
//
// usage:
//   req channel (req_valid/req_ready/req) takes one item per transfer: a
//   message byte (kind 0) or the end-of-message mark (kind 1).
//   rsp channel (rsp_valid/rsp_ready/rsp) gives the five digest words,
//   word_index 0 first, last_word high on the fifth, only after an end mark.
// sequence:
//   a data byte is taken while idle; the 64th byte of a block starts a compression
//   (load, 80 rounds through the single round adder, chain add).
//   an end mark pads the block and compresses it, plus a second block when the
//   length field spills over, then the digest words.
//   req_ready is low while the round unit or the digest output is busy.
// reset:
//   chaining words return to the initial hash values, byte count to zero;
//   after the fifth word transfers the block clears itself the same way.
// stall:
//   each digest word holds on rsp until taken; the engine waits meanwhile.
module sha1_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sha1_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output sha1_pkg::out_item_t  rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(sha1_pkg::ROUNDS - 1);
    localparam logic [6:0] R20 = 7'd20;
    localparam logic [6:0] R40 = 7'd40;
    localparam logic [6:0] R60 = 7'd60;
    localparam logic [2:0] LAST_IDX = 3'(sha1_pkg::DIGEST_WORDS - 1);

    logic [2:0]                 state_reg, state_next;
    logic [6:0]                 round_reg, round_next;
    logic [2:0]                 word_reg, word_next;
    logic                       final_reg, final_next;
    logic                       second_reg, second_next;
    logic [sha1_pkg::TOTAL_W-1:0] total_reg, total_next;
    sha1_pkg::word_t            chain_reg [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::word_t            chain_next [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::word_t            var_reg [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::word_t            var_next [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::word_t            win_reg [sha1_pkg::WINDOW_WORDS];
    sha1_pkg::word_t            win_next [sha1_pkg::WINDOW_WORDS];

    logic                       req_xfer;
    logic                       rsp_xfer;
    logic [5:0]                 pos;
    logic [63:0]                bit_len;
    sha1_pkg::word_t            f_val;
    sha1_pkg::word_t            k_val;
    sha1_pkg::word_t            w_new;
    sha1_pkg::word_t            t_sum;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_EMIT);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_xfer  = rsp_valid && rsp_ready;
    assign pos       = total_reg[5:0];
    assign bit_len   = {total_reg, 3'b000};

    // digest word straight from the chaining registers, held while stalled
    assign rsp.digest_word = chain_reg[word_reg];
    assign rsp.word_index  = word_reg;
    assign rsp.last_word   = (word_reg == LAST_IDX);

    // round function and constant by round group
    always_comb
    begin
        if (round_reg < R20)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = sha1_pkg::K0;
        end
        else if (round_reg < R40)
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = sha1_pkg::K1;
        end
        else if (round_reg < R60)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = sha1_pkg::K2;
        end
        else
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = sha1_pkg::K3;
        end
    end

    // shared round adder and schedule expansion
    sha1_pkg::word_t w_mix;
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign t_sum = {var_reg[0][26:0], var_reg[0][31:27]} + f_val + var_reg[4]
                 + win_reg[0] + k_val;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        word_next   = word_reg;
        final_next  = final_reg;
        second_next = second_reg;
        total_next  = total_reg;
        chain_next  = chain_reg;
        var_next    = var_reg;
        win_next    = win_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.kind == sha1_pkg::KIND_DATA)
                    begin
                        // place the byte big-endian in its word
                        for (int j = 0; j < 4; j++)
                        begin
                            if (pos[1:0] == 2'(j))
                                win_next[pos[5:2]][8*(3-j) +: 8] = req.data_byte;
                        end
                        total_next = total_reg + 1'b1;
                        if (pos == 6'd63)
                        begin
                            final_next = 1'b0;
                            state_next = ST_START;
                        end
                    end
                    else
                    begin
                        // pad mark at pos, zeros after it
                        for (int i = 0; i < sha1_pkg::WINDOW_WORDS; i++)
                        begin
                            for (int j = 0; j < 4; j++)
                            begin
                                if (6'(i*4 + j) == pos)
                                    win_next[i][8*(3-j) +: 8] = sha1_pkg::PAD_BYTE;
                                else if (6'(i*4 + j) > pos)
                                    win_next[i][8*(3-j) +: 8] = 8'h00;
                            end
                        end
                        // length fits in this block unless the pad reached the tail
                        if (pos[5:3] != 3'b111)
                        begin
                            win_next[14] = bit_len[63:32];
                            win_next[15] = bit_len[31:0];
                        end
                        second_next = (pos[5:3] == 3'b111);
                        final_next  = 1'b1;
                        state_next  = ST_START;
                    end
                end
            end
            ST_START:
            begin
                var_next   = chain_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                var_next[4] = var_reg[3];
                var_next[3] = var_reg[2];
                var_next[2] = {var_reg[1][1:0], var_reg[1][31:2]};
                var_next[1] = var_reg[0];
                var_next[0] = t_sum;
                for (int i = 0; i < sha1_pkg::WINDOW_WORDS - 1; i++)
                    win_next[i] = win_reg[i+1];
                win_next[sha1_pkg::WINDOW_WORDS-1] = w_new;
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++)
                    chain_next[i] = chain_reg[i] + var_reg[i];
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (second_reg)
                begin
                    // extra block holding only the length
                    for (int i = 0; i < sha1_pkg::WINDOW_WORDS; i++)
                        win_next[i] = '0;
                    win_next[14] = bit_len[63:32];
                    win_next[15] = bit_len[31:0];
                    second_next  = 1'b0;
                    state_next   = ST_START;
                end
                else
                begin
                    word_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rsp_xfer)
                begin
                    word_next = word_reg + 1'b1;
                    if (word_reg == LAST_IDX)
                    begin
                        for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++)
                            chain_next[i] = sha1_pkg::init_word(3'(i));
                        total_next = '0;
                        final_next = 1'b0;
                        word_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            word_reg   <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            total_reg  <= '0;
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++)
                chain_reg[i] <= sha1_pkg::init_word(3'(i));
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            word_reg   <= word_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            total_reg  <= total_next;
            chain_reg  <= chain_next;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
        win_reg <= win_next;
    end

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("input taken while digest is being sent");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (word_reg <= LAST_IDX))
        else $error("digest word index out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_xfer && rsp.last_word) |=> (req_ready && total_reg == '0))
        else $error("block not cleared after last digest word");

    a_end_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && req.kind == sha1_pkg::KIND_END) |=> (state_reg == ST_START && final_reg))
        else $error("end mark did not start the final compression");

endmodule
